// ----- rtl/tcc_pkg.sv -----
`default_nettype none

package tcc_pkg;

    // Field widths
    localparam int CODE_W  = 8;
    localparam int COLS_W  = 8;
    localparam int ROWS_W  = 7;
    localparam int PIX_X_W = 12;
    localparam int PIX_Y_W = 11;
    localparam int POS_W   = 15;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 8;

    // Cell geometry in pixels
    localparam int CELL_W = 9;
    localparam int CELL_H = 14;

    // Character codes
    localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CODE_W-1:0] CODE_SPACE     = 8'd32;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_CONSOLE_COLS = 2'd0;
    localparam logic [IDX_W-1:0] REG_CONSOLE_ROWS = 2'd1;

    // Register reset values
    localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd25;

    typedef struct packed {
        logic [COLS_W-1:0] cols;
        logic [ROWS_W-1:0] rows;
    } cfg_t;

    typedef struct packed {
        logic [COLS_W-1:0] col;
        logic [ROWS_W-1:0] row;
    } cursor_t;

    typedef struct packed {
        logic               draw_valid;
        logic [CODE_W-1:0]  draw_code;
        logic [PIX_X_W-1:0] pixel_x;
        logic [PIX_Y_W-1:0] pixel_y;
        logic               scroll_req;
        logic [POS_W-1:0]   cursor_pos;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/tcc_if.sv -----
`default_nettype none

// Character request channel
interface tcc_char_if;
    import tcc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

// Draw / cursor result channel
interface tcc_draw_if;
    import tcc_pkg::*;
    logic               valid;
    logic               ready;
    logic               draw_valid;
    logic [CODE_W-1:0]  draw_code;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
    logic               scroll_req;
    logic [POS_W-1:0]   cursor_pos;

    modport source (output valid, output draw_valid, output draw_code, output pixel_x,
                    output pixel_y, output scroll_req, output cursor_pos, input ready);
    modport sink   (input valid, input draw_valid, input draw_code, input pixel_x,
                    input pixel_y, input scroll_req, input cursor_pos, output ready);
endinterface

// Register write channel
interface tcc_cfg_if;
    import tcc_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/tcc_cfg_regs.sv -----
`default_nettype none

module tcc_cfg_regs
    import tcc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tcc_cfg_if.sink    cfg,
    output cfg_t       cfg_out
);

    logic [COLS_W-1:0] cols_reg;
    logic [ROWS_W-1:0] rows_reg;

    // Writes are always taken; unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.reg_index == REG_CONSOLE_COLS)
            begin
                cols_reg <= cfg.wdata[COLS_W-1:0];
            end
            if (cfg.reg_index == REG_CONSOLE_ROWS)
            begin
                rows_reg <= cfg.wdata[ROWS_W-1:0];
            end
        end
    end

    assign cfg_out.cols = cols_reg;
    assign cfg_out.rows = rows_reg;

endmodule

`default_nettype wire

// ----- rtl/tcc_step.sv -----
`default_nettype none

module tcc_step
    import tcc_pkg::*;
(
    input  wire logic [CODE_W-1:0] code,
    input  wire cursor_t           cur,
    input  wire cfg_t              cfg_in,
    output cursor_t                cursor_next,
    output result_t                res
);

    logic [COLS_W-1:0] cols_eff;
    logic [ROWS_W-1:0] rows_eff;
    logic [ROWS_W:0]   row_inc;
    logic [COLS_W:0]   col_inc;
    logic              row_last;
    logic              col_last;
    logic [ROWS_W-1:0] nl_row;
    cursor_t           draw_at;

    // Zero size behaves as one
    assign cols_eff = (cfg_in.cols == '0) ? COLS_W'(1) : cfg_in.cols;
    assign rows_eff = (cfg_in.rows == '0) ? ROWS_W'(1) : cfg_in.rows;

    // Row advance, scroll on the last row or past it
    assign row_inc  = {1'b0, cur.row} + (ROWS_W+1)'(1);
    assign row_last = (row_inc >= {1'b0, rows_eff});
    assign nl_row   = row_last ? (rows_eff - ROWS_W'(1)) : row_inc[ROWS_W-1:0];

    assign col_inc  = {1'b0, cur.col} + (COLS_W+1)'(1);
    assign col_last = (col_inc >= {1'b0, cols_eff});

    // Cursor update and draw request
    always_comb
    begin
        cursor_next    = cur;
        draw_at        = cur;
        res.draw_valid = 1'b0;
        res.draw_code  = '0;
        res.scroll_req = 1'b0;
        priority if (code == CODE_NEWLINE)
        begin
            cursor_next.col = '0;
            cursor_next.row = nl_row;
            res.scroll_req  = row_last;
        end
        else if (code == CODE_BACKSPACE)
        begin
            if (cur.col != '0 || cur.row != '0)
            begin
                if (cur.col != '0)
                begin
                    cursor_next.col = cur.col - COLS_W'(1);
                end
                else
                begin
                    cursor_next.col = cols_eff - COLS_W'(1);
                    cursor_next.row = cur.row - ROWS_W'(1);
                end
                draw_at        = cursor_next;
                res.draw_valid = 1'b1;
                res.draw_code  = CODE_SPACE;
            end
        end
        else
        begin
            res.draw_valid = 1'b1;
            res.draw_code  = code;
            if (col_last)
            begin
                cursor_next.col = '0;
                cursor_next.row = nl_row;
                res.scroll_req  = row_last;
            end
            else
            begin
                cursor_next.col = col_inc[COLS_W-1:0];
            end
        end

        // Cell origin in pixels, zero when nothing is drawn
        res.pixel_x = res.draw_valid ?
                      PIX_X_W'(draw_at.col) * PIX_X_W'(CELL_W) : '0;
        res.pixel_y = res.draw_valid ?
                      PIX_Y_W'(draw_at.row) * PIX_Y_W'(CELL_H) : '0;

        // Linear position uses the raw column count
        res.cursor_pos = POS_W'(cursor_next.col)
                       + POS_W'(cursor_next.row) * POS_W'(cfg_in.cols);
    end

endmodule

`default_nettype wire

// ----- rtl/text_console_cursor_engine.sv -----
// Text console cursor engine. Each character request (newline, backspace or a
// printable code) moves the cursor held as column and row and returns one result:
// an optional glyph draw at a 9 by 14 pixel cell, a scroll request and the new
// linear cursor position. One request is taken every clock cycle unless the result
// channel stalls; a result passes the input register, then the cursor update and
// result register, and a new request can be taken while the last one is in flight.
// Console size registers (index 0 columns, index 1 rows; a size of zero acts as one
// for cursor movement) must be written through the configuration channel only
// while no request is in flight; the block itself does not enforce this.
`default_nettype none

module text_console_cursor_engine
    import tcc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tcc_cfg_if.sink     cfg,
    tcc_char_if.sink    char_in,
    tcc_draw_if.source  draw_out
);

    cfg_t              cfg_cur;
    logic              in_valid_reg;
    logic [CODE_W-1:0] code_reg;
    cursor_t           cursor_reg;
    cursor_t           cursor_next;
    result_t           res;
    logic              out_valid_reg;
    result_t           res_reg;
    logic              out_en;
    logic              adv;

    tcc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    tcc_step u_step (
        .code        (code_reg),
        .cur         (cursor_reg),
        .cfg_in      (cfg_cur),
        .cursor_next (cursor_next),
        .res         (res)
    );

    // Pipeline flow control
    assign out_en        = !out_valid_reg || draw_out.ready;
    assign char_in.ready = !in_valid_reg || out_en;
    assign adv           = in_valid_reg && out_en;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (char_in.ready)
        begin
            in_valid_reg <= char_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.valid && char_in.ready)
        begin
            code_reg <= char_in.char_code;
        end
    end

    // Cursor state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_en)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (adv)
            begin
                cursor_reg <= cursor_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res;
        end
    end

    assign draw_out.valid      = out_valid_reg;
    assign draw_out.draw_valid = res_reg.draw_valid;
    assign draw_out.draw_code  = res_reg.draw_code;
    assign draw_out.pixel_x    = res_reg.pixel_x;
    assign draw_out.pixel_y    = res_reg.pixel_y;
    assign draw_out.scroll_req = res_reg.scroll_req;
    assign draw_out.cursor_pos = res_reg.cursor_pos;

`ifndef SYNTH
    logic [ROWS_W-1:0] rows_last;
    assign rows_last = (cfg_cur.rows == '0) ? '0 : (cfg_cur.rows - ROWS_W'(1));

    // A scroll parks the cursor at the start of the last row
    a_scroll_parks: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res.scroll_req) |=>
            (cursor_reg.col == '0 && cursor_reg.row == $past(rows_last)))
        else $error("scroll did not park cursor");

    // Newline never requests a draw
    a_newline_no_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && code_reg == CODE_NEWLINE) |=> (out_valid_reg && !res_reg.draw_valid))
        else $error("newline produced a draw");

    // Backspace at home position leaves the cursor and draws nothing
    a_bs_home: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && code_reg == CODE_BACKSPACE && cursor_reg == '0) |=>
            (cursor_reg == '0 && !res_reg.draw_valid && res_reg.cursor_pos == '0))
        else $error("backspace at home moved cursor");

    // Cursor only moves when a request passes the compute stage
    a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(cursor_reg))
        else $error("cursor changed without a request");
`endif

endmodule

`default_nettype wire
